@@ rtl/swhs_pkg.sv @@
// Package for the single-wire humidity sensor reader.
// Holds the defaults, codes, shared structs and the divide-by-ten helper.
// No dependencies.
`default_nettype none

package swhs_pkg;

    localparam int FRAME_BITS_DEF       = 40;
    localparam int SKIP_TRANSITIONS_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] START_LOW_RST  = 16'd18000;
    localparam logic [7:0]  RELEASE_RST    = 8'd40;
    localparam logic [7:0]  THRESHOLD_RST  = 8'd16;
    localparam logic [7:0]  TIMEOUT_RST    = 8'd255;
    localparam logic [6:0]  MAX_TRANS_RST  = 7'd85;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW = 3'd0,
        CFG_RELEASE   = 3'd1,
        CFG_THRESHOLD = 3'd2,
        CFG_TIMEOUT   = 3'd3,
        CFG_MAX_TRANS = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOW    = 2'd1,
        PH_REL    = 2'd2,
        PH_LISTEN = 2'd3
    } phase_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  one_threshold;
        logic [7:0]  level_timeout;
        logic [6:0]  max_transitions;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       valid;
        logic [7:0] hum_whole;
        logic [7:0] hum_tenths;
        logic [7:0] temp_whole;
        logic [7:0] temp_tenths;
        logic [8:0] hum_value;
        logic [8:0] temp_value;
    } result_t;

    // x / 10 for 8-bit x by reciprocal multiply: (x * 205) >> 11
    function automatic logic [7:0] div10(input logic [7:0] x);
        logic [18:0] p;
        p = 19'(x) * 19'd205;
        return p[18:11];
    endfunction

endpackage

`default_nettype wire

@@ rtl/swhs_cfg.sv @@
// Configuration register bank of the humidity sensor reader.
// Depends on swhs_pkg.
`default_nettype none

module swhs_cfg
    import swhs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks <= START_LOW_RST;
            cfg_reg.release_ticks   <= RELEASE_RST;
            cfg_reg.one_threshold   <= THRESHOLD_RST;
            cfg_reg.level_timeout   <= TIMEOUT_RST;
            cfg_reg.max_transitions <= MAX_TRANS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_LOW: cfg_reg.start_low_ticks <= cfg_wdata;
                CFG_RELEASE:   cfg_reg.release_ticks   <= cfg_wdata[7:0];
                CFG_THRESHOLD: cfg_reg.one_threshold   <= cfg_wdata[7:0];
                CFG_TIMEOUT:   cfg_reg.level_timeout   <= cfg_wdata[7:0];
                CFG_MAX_TRANS: cfg_reg.max_transitions <= cfg_wdata[6:0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/swhs_core.sv @@
// Read sequencer of the humidity sensor reader: phase, level timing,
// bit capture and checksum for one tick. Depends on swhs_pkg.
`default_nettype none

module swhs_core
    import swhs_pkg::*;
#(
    parameter int FRAME_BITS       = FRAME_BITS_DEF,
    parameter int SKIP_TRANSITIONS = SKIP_TRANSITIONS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic tick_en,
    input  wire logic line_level,
    input  wire logic start_req,
    input  wire cfg_t cfg,
    output result_t   res
);

    localparam int BC_W = $clog2(FRAME_BITS + 1);

    phase_t                phase_reg,  phase_next;
    logic [15:0]           ticks_reg,  ticks_next;
    logic [7:0]            lw_reg,     lw_next;
    logic                  last_reg,   last_next;
    logic [6:0]            ti_reg,     ti_next;
    logic [FRAME_BITS-1:0] rb_reg,     rb_next;
    logic [BC_W-1:0]       bc_reg,     bc_next;

    logic        drive;
    logic        finish;
    logic        good;
    logic [63:0] rb_ext;
    logic [7:0]  b0, b1, b2, b3, sum;

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        lw_next    = lw_reg;
        last_next  = last_reg;
        ti_next    = ti_reg;
        rb_next    = rb_reg;
        bc_next    = bc_reg;
        drive      = 1'b0;
        finish     = 1'b0;

        if (phase_next == PH_IDLE && start_req)
        begin
            phase_next = PH_LOW;
            ticks_next = '0;
            lw_next    = '0;
            last_next  = 1'b1;
            ti_next    = '0;
            rb_next    = '0;
            bc_next    = '0;
        end

        if (phase_next == PH_LOW)
        begin
            drive      = 1'b1;
            ticks_next = ticks_next + 16'd1;
            if (ticks_next >= cfg.start_low_ticks || ticks_next == 16'd0)
            begin
                phase_next = PH_REL;
                ticks_next = '0;
            end
        end
        else if (phase_next == PH_REL)
        begin
            if (ticks_next >= 16'(cfg.release_ticks))
            begin
                phase_next = PH_LISTEN;
                lw_next    = '0;
                last_next  = 1'b1;
            end
            else
            begin
                ticks_next = ticks_next + 16'd1;
            end
        end

        if (phase_next == PH_LISTEN && !drive)
        begin
            if (line_level == last_next)
            begin
                if (lw_next >= cfg.level_timeout)
                    finish = 1'b1;
                else
                    lw_next = lw_next + 8'd1;
            end
            else
            begin
                // data bits sit on the even transitions after the preamble
                if (ti_next >= 7'(SKIP_TRANSITIONS) && !ti_next[0] &&
                    bc_next < BC_W'(FRAME_BITS))
                begin
                    rb_next = {rb_next[FRAME_BITS-2:0], (lw_next > cfg.one_threshold)};
                    bc_next = bc_next + 1'b1;
                end
                last_next = line_level;
                lw_next   = 8'd1;
                ti_next   = ti_next + 7'd1;
                if (ti_next >= cfg.max_transitions || ti_next == 7'd0)
                    finish = 1'b1;
            end
            if (finish)
                phase_next = PH_IDLE;
        end
    end

    // frame bytes in the fixed 40-bit layout, checksum is the lowest byte
    assign rb_ext = 64'(rb_next);
    assign b0     = rb_ext[39:32];
    assign b1     = rb_ext[31:24];
    assign b2     = rb_ext[23:16];
    assign b3     = rb_ext[15:8];
    assign sum    = b0 + b1 + b2 + b3;
    assign good   = finish && (bc_next >= BC_W'(FRAME_BITS)) && (sum == rb_ext[7:0]);

    always_comb
    begin
        res             = '0;
        res.drive_low   = drive;
        res.busy        = (phase_next != PH_IDLE);
        res.done        = finish;
        res.valid       = good;
        if (good)
        begin
            res.hum_whole   = b0;
            res.hum_tenths  = b1;
            res.temp_whole  = b2;
            res.temp_tenths = b3;
            res.hum_value   = 9'(b0) + 9'(div10(b1));
            res.temp_value  = 9'(b2) + 9'(div10(b3));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            lw_reg    <= '0;
            last_reg  <= 1'b1;
            ti_reg    <= '0;
            rb_reg    <= '0;
            bc_reg    <= '0;
        end
        else if (tick_en)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            lw_reg    <= lw_next;
            last_reg  <= last_next;
            ti_reg    <= ti_next;
            rb_reg    <= rb_next;
            bc_reg    <= bc_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tick_en && res.done |=> phase_reg == PH_IDLE)
        else $error("read finished but phase not idle");

    a_drive_phase: assert property (@(posedge clk) disable iff (!rst_n)
        tick_en && res.drive_low |=> phase_reg == PH_LOW || phase_reg == PH_REL)
        else $error("line driven outside start pulse");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_en |=> $stable(phase_reg) && $stable(bc_reg) && $stable(rb_reg))
        else $error("state moved without a tick");

    a_valid_full: assert property (@(posedge clk) disable iff (!rst_n)
        tick_en && res.valid |-> res.done && bc_next == BC_W'(FRAME_BITS))
        else $error("valid result without a full frame");

endmodule

`default_nettype wire

@@ rtl/single_wire_humidity_sensor_reader_unit.sv @@
// Top level of the single-wire humidity sensor reader.
// Instantiates swhs_cfg and swhs_core; depends on swhs_pkg.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | line_level, start_req (one tick per item)
//  out     | out_valid / out_ready | drive_low, busy_res, done_res, valid_res,
//          |                       | four frame bytes, two 9-bit values
//  cfg     | cfg_we                | cfg_index, cfg_wdata (write only)
//
// One result item per input item, one item per cycle sustained while out_ready stays high;
// an item passes the input register, then the sequencer step into the result register.
// The sequencer step is a single pass of short logic: phase counters, one
// bit shift and a four-byte checksum add.
// Reset clears the config to its defaults and the sequencer to idle.
// A stalled output holds its item; the input register keeps one item more,
// so in_ready drops only when both are full.
`default_nettype none

module single_wire_humidity_sensor_reader_unit
    import swhs_pkg::*;
#(
    parameter int FRAME_BITS       = FRAME_BITS_DEF,
    parameter int SKIP_TRANSITIONS = SKIP_TRANSITIONS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input items
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic                  line_level,
    input  wire logic                  start_req,
    // result items
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic                  drive_low,
    output      logic                  busy_res,
    output      logic                  done_res,
    output      logic                  valid_res,
    output      logic [7:0]            humidity_whole,
    output      logic [7:0]            humidity_tenths,
    output      logic [7:0]            temperature_whole,
    output      logic [7:0]            temperature_tenths,
    output      logic [8:0]            humidity_value,
    output      logic [8:0]            temperature_value,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    logic s1_valid_reg;
    logic s1_line_reg;
    logic s1_start_reg;
    logic out_valid_reg;
    logic advance;
    logic tick_en;

    // result register free or emptying this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign tick_en  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    swhs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swhs_core #(
        .FRAME_BITS       (FRAME_BITS),
        .SKIP_TRANSITIONS (SKIP_TRANSITIONS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (tick_en),
        .line_level (s1_line_reg),
        .start_req  (s1_start_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (tick_en)
                s1_valid_reg <= 1'b0;

            if (tick_en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_line_reg  <= line_level;
            s1_start_reg <= start_req;
        end
        if (tick_en)
            res_reg <= res;
    end

    assign out_valid          = out_valid_reg;
    assign drive_low          = res_reg.drive_low;
    assign busy_res           = res_reg.busy;
    assign done_res           = res_reg.done;
    assign valid_res          = res_reg.valid;
    assign humidity_whole     = res_reg.hum_whole;
    assign humidity_tenths    = res_reg.hum_tenths;
    assign temperature_whole  = res_reg.temp_whole;
    assign temperature_tenths = res_reg.temp_tenths;
    assign humidity_value     = res_reg.hum_value;
    assign temperature_value  = res_reg.temp_value;

endmodule

`default_nettype wire
